/* rtl/shape_coverage_alpha_blend_defines.svh */
// assertion helpers for the top-level rtl
`ifndef SHAPE_COVERAGE_ALPHA_BLEND_DEFINES_SVH
`define SHAPE_COVERAGE_ALPHA_BLEND_DEFINES_SVH

// same-cycle implication
`define SCA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/sca_pkg.sv */
package sca_pkg;

   localparam int FRAME_WIDTH  = 2048;
   localparam int FRAME_HEIGHT = 2048;

   typedef enum logic [2:0] {
      SHAPE_CIRCLE      = 3'd0,
      SHAPE_CIRCLE_RING = 3'd1,
      SHAPE_DIAMOND     = 3'd2,
      SHAPE_DIAMOND_RING = 3'd3,
      SHAPE_RECT        = 3'd4,
      SHAPE_RECT_BORDER = 3'd5
   } shape_kind_type;

   typedef enum logic [2:0] {
      CSR_SHAPE_KIND     = 3'd0,
      CSR_POINT_A        = 3'd1,
      CSR_POINT_B        = 3'd2,
      CSR_RADIUS         = 3'd3,
      CSR_RING_WIDTH     = 3'd4,
      CSR_FILL_COLOR     = 3'd5,
      CSR_ALPHA          = 3'd6,
      CSR_ALPHA_ONE_MODE = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  shape_kind;
      logic [31:0] point_a;
      logic [31:0] point_b;
      logic [15:0] radius;
      logic [15:0] ring_width;
      logic [23:0] fill_color;
      logic [7:0]  alpha;
      logic        alpha_one_mode;
   } cfg_type;

   typedef struct packed {
      logic s1;
      logic s2;
   } stage_en_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

endpackage

/* rtl/sca_cover.sv */
module sca_cover #(
   parameter int FRAME_WIDTH  = sca_pkg::FRAME_WIDTH,
   parameter int FRAME_HEIGHT = sca_pkg::FRAME_HEIGHT
) (
   input  logic                clock,
   input  sca_pkg::cfg_type    cfg,
   input  sca_pkg::stage_en_type en,
   input  logic [10:0]         row,
   input  logic [10:0]         column,
   output logic                covered
);
   import sca_pkg::*;

   function automatic logic near_edge(logic signed [19:0] v, logic signed [19:0] e,
                                      logic signed [19:0] bw);
      logic signed [19:0] d;
      d = v - e;
      return ((d[19] ? -d : d) <= bw);
   endfunction

   // stage 1: offsets from the center
   logic [14:0]        x_pos;
   logic [14:0]        y_pos;
   logic signed [17:0] dx;
   logic signed [17:0] dy;
   logic [16:0]        adx_in, adx_ff;
   logic [16:0]        ady_in, ady_ff;
   logic [14:0]        x_ff, y_ff;
   logic               frame1_in, frame1_ff;

   always_comb begin
      x_pos     = {column, 4'b0000};
      y_pos     = {row, 4'b0000};
      dx        = 18'($signed({3'b000, x_pos})) - 18'($signed(cfg.point_a[15:0]));
      dy        = 18'($signed({3'b000, y_pos})) - 18'($signed(cfg.point_a[31:16]));
      adx_in    = dx[17] ? 17'(-dx) : dx[16:0];
      ady_in    = dy[17] ? 17'(-dy) : dy[16:0];
      frame1_in = ({2'b00, row} < 13'(FRAME_HEIGHT)) && ({2'b00, column} < 13'(FRAME_WIDTH));
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         adx_ff    <= adx_in;
         ady_ff    <= ady_in;
         x_ff      <= x_pos;
         y_ff      <= y_pos;
         frame1_ff <= frame1_in;
      end
   end

   // stage 2: squares, diamond and rectangle tests
   logic [17:0]        outer;
   logic signed [18:0] inner_s;
   logic [17:0]        inner;
   logic [17:0]        l1;
   logic [18:0]        l1x2;
   logic [15:0]        xlo, xhi, ylo, yhi;
   logic signed [19:0] xlo_s, xhi_s, ylo_s, yhi_s;
   logic signed [19:0] xs, ys, x2, y2, xlo2, xhi2, ylo2, yhi2, bw;
   logic               grown;
   logic [33:0]        sqx_in, sqx_ff, sqy_in, sqy_ff;
   logic [31:0]        r2_in, r2_ff;
   logic [35:0]        outer2_in, outer2_ff, inner2_in, inner2_ff;
   logic               dia_in, dia_ff, dring_in, dring_ff;
   logic               rect_in, rect_ff, rborder_in, rborder_ff;
   logic               frame2_ff;

   always_comb begin
      outer   = {1'b0, cfg.radius, 1'b0} + 18'(cfg.ring_width);
      inner_s = $signed({2'b00, cfg.radius, 1'b0}) - $signed({3'b000, cfg.ring_width});
      inner   = inner_s[18] ? 18'd0 : inner_s[17:0];

      sqx_in    = 34'(adx_ff) * 34'(adx_ff);
      sqy_in    = 34'(ady_ff) * 34'(ady_ff);
      r2_in     = 32'(cfg.radius) * 32'(cfg.radius);
      outer2_in = 36'(outer) * 36'(outer);
      inner2_in = 36'(inner) * 36'(inner);

      l1       = 18'(adx_ff) + 18'(ady_ff);
      l1x2     = {l1, 1'b0};
      dia_in   = l1 <= 18'(cfg.radius);
      dring_in = (l1x2 <= 19'(outer)) && (l1x2 >= 19'(inner));

      if ($signed(cfg.point_a[15:0]) < $signed(cfg.point_b[15:0])) begin
         xlo = cfg.point_a[15:0];
         xhi = cfg.point_b[15:0];
      end else begin
         xlo = cfg.point_b[15:0];
         xhi = cfg.point_a[15:0];
      end
      if ($signed(cfg.point_a[31:16]) < $signed(cfg.point_b[31:16])) begin
         ylo = cfg.point_a[31:16];
         yhi = cfg.point_b[31:16];
      end else begin
         ylo = cfg.point_b[31:16];
         yhi = cfg.point_a[31:16];
      end
      xlo_s = 20'($signed(xlo));
      xhi_s = 20'($signed(xhi));
      ylo_s = 20'($signed(ylo));
      yhi_s = 20'($signed(yhi));
      xs    = $signed({5'b00000, x_ff});
      ys    = $signed({5'b00000, y_ff});
      rect_in = (xs >= xlo_s) && (xs <= xhi_s) && (ys >= ylo_s) && (ys <= yhi_s);

      x2   = $signed({4'b0000, x_ff, 1'b0});
      y2   = $signed({4'b0000, y_ff, 1'b0});
      xlo2 = {xlo_s[18:0], 1'b0};
      xhi2 = {xhi_s[18:0], 1'b0};
      ylo2 = {ylo_s[18:0], 1'b0};
      yhi2 = {yhi_s[18:0], 1'b0};
      bw   = $signed({4'b0000, cfg.ring_width});
      grown = (x2 >= xlo2 - bw) && (x2 <= xhi2 + bw) &&
              (y2 >= ylo2 - bw) && (y2 <= yhi2 + bw);
      rborder_in = grown && (near_edge(y2, ylo2, bw) || near_edge(x2, xlo2, bw) ||
                             near_edge(y2, yhi2, bw) || near_edge(x2, xhi2, bw));
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         sqx_ff     <= sqx_in;
         sqy_ff     <= sqy_in;
         r2_ff      <= r2_in;
         outer2_ff  <= outer2_in;
         inner2_ff  <= inner2_in;
         dia_ff     <= dia_in;
         dring_ff   <= dring_in;
         rect_ff    <= rect_in;
         rborder_ff <= rborder_in;
         frame2_ff  <= frame1_ff;
      end
   end

   // circle compares and shape select
   logic [34:0] sum;
   logic [36:0] sum4;
   logic        hit;

   always_comb begin
      sum  = 35'(sqx_ff) + 35'(sqy_ff);
      sum4 = {sum, 2'b00};
      case (cfg.shape_kind)
         SHAPE_CIRCLE:       hit = sum <= 35'(r2_ff);
         SHAPE_CIRCLE_RING:  hit = (sum4 <= 37'(outer2_ff)) && (sum4 >= 37'(inner2_ff));
         SHAPE_DIAMOND:      hit = dia_ff;
         SHAPE_DIAMOND_RING: hit = dring_ff;
         SHAPE_RECT:         hit = rect_ff;
         SHAPE_RECT_BORDER:  hit = rborder_ff;
         default:            hit = 1'b0;
      endcase
      covered = frame2_ff && hit;
   end

endmodule

/* rtl/sca_blend.sv */
module sca_blend (
   input  logic                 clock,
   input  sca_pkg::cfg_type     cfg,
   input  sca_pkg::stage_en_type en,
   input  sca_pkg::pixel_type   old_pixel,
   output sca_pkg::pixel_type   pass_pixel,
   output sca_pkg::pixel_type   mix_pixel
);
   import sca_pkg::*;

   // floor(x / 255) for x up to 255 * 255
   function automatic logic [7:0] div255(logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'd1 + 17'(x[15:8]);
      return t[15:8];
   endfunction

   logic [2:0][7:0]  fill;
   logic [2:0][7:0]  prev;
   logic [7:0]       inv_alpha;
   logic [2:0][15:0] ca_in, ca_ff, pq_in, pq_ff;
   logic [2:0][7:0]  p1_ff, p2_ff;
   logic [7:0]       a1_ff, a2_ff;
   logic [2:0][7:0]  mix_in, mix_ff;
   logic [2:0][15:0] sum;
   logic [2:0][8:0]  add;

   always_comb begin
      fill      = {cfg.fill_color[7:0], cfg.fill_color[15:8], cfg.fill_color[23:16]};
      prev      = {old_pixel.blue, old_pixel.green, old_pixel.red};
      inv_alpha = 8'd255 - cfg.alpha;
      for (int i = 0; i < 3; i++) begin
         ca_in[i] = 16'(fill[i]) * 16'(cfg.alpha);
         pq_in[i] = 16'(prev[i]) * 16'(inv_alpha);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         ca_ff <= ca_in;
         pq_ff <= pq_in;
         p1_ff <= prev;
         a1_ff <= old_pixel.alpha;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i] = 16'(17'(ca_ff[i]) + 17'(pq_ff[i]));
         add[i] = 9'(div255(ca_ff[i])) + 9'(p1_ff[i]);
         if (cfg.alpha_one_mode) begin
            mix_in[i] = add[i][8] ? 8'hff : add[i][7:0];
         end else begin
            mix_in[i] = div255(sum[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         mix_ff <= mix_in;
         p2_ff  <= p1_ff;
         a2_ff  <= a1_ff;
      end
   end

   always_comb begin
      pass_pixel.red   = p2_ff[0];
      pass_pixel.green = p2_ff[1];
      pass_pixel.blue  = p2_ff[2];
      pass_pixel.alpha = a2_ff;
      mix_pixel.red    = mix_ff[0];
      mix_pixel.green  = mix_ff[1];
      mix_pixel.blue   = mix_ff[2];
      mix_pixel.alpha  = 8'hff;
   end

endmodule

/* rtl/shape_coverage_alpha_blend.sv */
// channel   ports            payload
// req       req_t*           tdata: row, column, old_red, old_green, old_blue, old_alpha
// rsp       rsp_t*           tdata: new_red, new_green, new_blue, new_alpha, covered
// csr       csr_*            index 0..7 selects the register, data holds its value
//
// one pixel per clock sustained while rsp_tready is high; four register stages from accept to rsp_tvalid
// (input, offsets and products, squares and blend divide, output select)
// the squaring multipliers set the stage depth
// each stage moves when the one after it is empty or moving; rsp_tready low holds a full pipe
// reset is synchronous, empties the pipeline and restores register defaults
// csr_ready is always high; write registers only while no pixel is in flight
`include "shape_coverage_alpha_blend_defines.svh"

module shape_coverage_alpha_blend #(
   parameter int FRAME_WIDTH  = sca_pkg::FRAME_WIDTH,
   parameter int FRAME_HEIGHT = sca_pkg::FRAME_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // row, column, old_red, old_green, old_blue, old_alpha, zero pad
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // new_red, new_green, new_blue, new_alpha, covered, zero pad
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import sca_pkg::*;

   // configuration registers
   cfg_type cfg_in, cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SHAPE_KIND:     cfg_in.shape_kind     = csr_data[2:0];
            CSR_POINT_A:        cfg_in.point_a        = csr_data;
            CSR_POINT_B:        cfg_in.point_b        = csr_data;
            CSR_RADIUS:         cfg_in.radius         = csr_data[15:0];
            CSR_RING_WIDTH:     cfg_in.ring_width     = csr_data[15:0];
            CSR_FILL_COLOR:     cfg_in.fill_color     = csr_data[23:0];
            CSR_ALPHA:          cfg_in.alpha          = csr_data[7:0];
            CSR_ALPHA_ONE_MODE: cfg_in.alpha_one_mode = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{shape_kind: SHAPE_CIRCLE, point_a: '0, point_b: '0, radius: '0,
                     ring_width: '0, fill_color: '0, alpha: 8'hff,
                     alpha_one_mode: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   // pipeline control
   logic         in_vld_in, in_vld_ff;
   logic         s1_vld_in, s1_vld_ff;
   logic         s2_vld_in, s2_vld_ff;
   logic         out_vld_in, out_vld_ff;
   logic         in_rdy, s1_rdy, s2_rdy, out_rdy;
   stage_en_type en;

   always_comb begin
      out_rdy    = !out_vld_ff || rsp_tready;
      s2_rdy     = !s2_vld_ff || out_rdy;
      s1_rdy     = !s1_vld_ff || s2_rdy;
      in_rdy     = !in_vld_ff || s1_rdy;
      en.s1      = in_vld_ff && s1_rdy;
      en.s2      = s1_vld_ff && s2_rdy;
      in_vld_in  = in_rdy  ? req_tvalid : in_vld_ff;
      s1_vld_in  = s1_rdy  ? in_vld_ff  : s1_vld_ff;
      s2_vld_in  = s2_rdy  ? s1_vld_ff  : s2_vld_ff;
      out_vld_in = out_rdy ? s2_vld_ff  : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign req_tready = in_rdy;
   assign rsp_tvalid = out_vld_ff;

   // input register
   logic [10:0] row_ff, column_ff;
   pixel_type   pix_ff;

   always_ff @(posedge clock) begin
      if (req_tvalid && in_rdy) begin
         row_ff       <= req_tdata[10:0];
         column_ff    <= req_tdata[21:11];
         pix_ff.red   <= req_tdata[29:22];
         pix_ff.green <= req_tdata[37:30];
         pix_ff.blue  <= req_tdata[45:38];
         pix_ff.alpha <= req_tdata[53:46];
      end
   end

   logic      covered;
   pixel_type pass_pixel, mix_pixel;

   sca_cover #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_cover (
      .clock   (clock),
      .cfg     (cfg_ff),
      .en      (en),
      .row     (row_ff),
      .column  (column_ff),
      .covered (covered)
   );

   sca_blend u_blend (
      .clock      (clock),
      .cfg        (cfg_ff),
      .en         (en),
      .old_pixel  (pix_ff),
      .pass_pixel (pass_pixel),
      .mix_pixel  (mix_pixel)
   );

   // output register
   pixel_type   sel_pixel;
   logic [39:0] rsp_data_in, rsp_data_ff;

   always_comb begin
      sel_pixel   = covered ? mix_pixel : pass_pixel;
      rsp_data_in = {7'b0000000, covered, sel_pixel.alpha, sel_pixel.blue,
                     sel_pixel.green, sel_pixel.red};
   end

   always_ff @(posedge clock) begin
      if (s2_vld_ff && out_rdy) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;

   `SCA_ASSERT_NOW(a_covered_opaque, clock, reset, rsp_tvalid && rsp_tdata[32], rsp_tdata[31:24] == 8'hff, "covered pixel without opaque alpha")
   `SCA_ASSERT_NOW(a_empty_input_ready, clock, reset, !in_vld_ff, req_tready, "input stage empty but not ready")
   `SCA_ASSERT_NOW(a_full_stall_blocks, clock, reset, in_vld_ff && s1_vld_ff && s2_vld_ff && rsp_tvalid && !rsp_tready, !req_tready, "full stalled pipeline still accepting")
   `SCA_ASSERT_NEXT(a_stall_keeps_s2, clock, reset, rsp_tvalid && !rsp_tready && s2_vld_ff, s2_vld_ff, "stage two item lost during stall")

endmodule
